// ----- rtl/core/jet_pkg.sv -----
// shared types, constants and helpers of the julia escape-time counter
// no dependencies; used by every module under rtl/core
package jet_pkg;

  localparam int COORD_BITS  = 32;
  localparam int LIMIT_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_REAL      = 2'd0;
  localparam logic [1:0] REG_OFFSET_IMAG      = 2'd1;
  localparam logic [1:0] REG_ITERATION_LIMIT  = 2'd2;
  localparam logic [1:0] REG_SETTLE_THRESHOLD = 2'd3;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] re;
    logic signed [COORD_BITS-1:0] im;
    logic                         zero_limit;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] offset_real;
    logic signed [COORD_BITS-1:0] offset_imag;
    logic [COORD_BITS-1:0]        settle_threshold;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_CHK,
    BK_DONE
  } back_state_t;

  // clamp to the signed 32 bit range
  function automatic logic signed [COORD_BITS-1:0] sat32(input logic signed [63:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_BITS-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/jet_front.sv -----
// input stage: takes start points and tags points with a zero limit
// depends on jet_pkg
module jet_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [jet_pkg::COORD_BITS-1:0] start_real,
  input  logic signed [jet_pkg::COORD_BITS-1:0] start_imag,
  input  logic [jet_pkg::LIMIT_BITS-1:0]      limit,
  input  jet_pkg::queue_stat_t                q_stat,
  output logic                                q_push,
  output jet_pkg::item_t                      q_item
);

  logic           item_valid;
  jet_pkg::item_t item;
  logic           accept;

  assign full   = item_valid && q_stat.full;
  assign accept = push && !full;
  assign q_push = item_valid && !q_stat.full;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (q_push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.re         <= start_real;
      item.im         <= start_imag;
      item.zero_limit <= (limit == '0);
    end
  end

endmodule

// ----- rtl/core/jet_queue.sv -----
// short queue between the input stage and the iteration engine
// depends on jet_pkg
module jet_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jet_pkg::item_t       push_item,
  input  logic                 pop,
  output jet_pkg::item_t       head,
  output jet_pkg::queue_stat_t stat
);

  jet_pkg::item_t                   slots [jet_pkg::QUEUE_DEPTH];
  logic [jet_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [jet_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [jet_pkg::QPTR_BITS:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign stat.full  = (count == (jet_pkg::QPTR_BITS+1)'(jet_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/core/jet_back.sv -----
// iteration engine: multiply, sum and check phases per step, plus result register
// depends on jet_pkg
module jet_back #(
  parameter int COUNT_BITS      = 16,
  parameter int COORD_FRAC_BITS = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  input  jet_pkg::item_t                    head,
  input  jet_pkg::queue_stat_t              q_stat,
  output logic                              q_pop,
  input  jet_pkg::cfg_t                     cfg,
  input  logic [jet_pkg::LIMIT_BITS-1:0]    limit,
  input  logic                              pop,
  output logic                              empty,
  output logic [COUNT_BITS-1:0]             iterations,
  output jet_pkg::back_stat_t               stat
);

  localparam logic [63:0] BOUND     = 64'(4) << (2 * COORD_FRAC_BITS);
  localparam logic [63:0] PREV_INIT = 64'(16) << (2 * COORD_FRAC_BITS);

  jet_pkg::back_state_t state, state_next;

  logic signed [jet_pkg::COORD_BITS-1:0] x;
  logic signed [jet_pkg::COORD_BITS-1:0] y;
  logic signed [63:0]                    xx;
  logic signed [63:0]                    yy;
  logic signed [63:0]                    xy;
  logic signed [63:0]                    dif;
  logic [63:0]                           modulus;
  logic [63:0]                           prev;
  logic [jet_pkg::LIMIT_BITS-1:0]        cnt;
  logic                                  first;
  logic                                  res_valid;
  logic [jet_pkg::LIMIT_BITS-1:0]        res_count;

  logic                                  start;
  logic                                  res_load;
  logic [63:0]                           thresh;
  logic [63:0]                           absdiff;
  logic                                  stop_chk;
  logic [jet_pkg::LIMIT_BITS-1:0]        cnt_upd;
  logic                                  at_limit;
  logic signed [63:0]                    nx_wide;
  logic signed [63:0]                    ny_wide;

  // check of the point reached by the previous step
  assign thresh   = 64'(cfg.settle_threshold) << COORD_FRAC_BITS;
  assign absdiff  = (prev > modulus) ? (prev - modulus) : (modulus - prev);
  assign stop_chk = !first && ((modulus > BOUND) || (absdiff < thresh));
  assign cnt_upd  = first ? cnt : cnt + 1'b1;
  assign at_limit = (cnt_upd >= limit);
  assign nx_wide  = (dif >>> COORD_FRAC_BITS) + 64'(cfg.offset_real);
  assign ny_wide  = (xy >>> (COORD_FRAC_BITS - 1)) + 64'(cfg.offset_imag);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jet_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_next = head.zero_limit ? jet_pkg::BK_DONE : jet_pkg::BK_MUL;
        end
      end
      jet_pkg::BK_MUL: state_next = jet_pkg::BK_SUM;
      jet_pkg::BK_SUM: state_next = jet_pkg::BK_CHK;
      jet_pkg::BK_CHK: begin
        state_next = (stop_chk || at_limit) ? jet_pkg::BK_DONE : jet_pkg::BK_MUL;
      end
      jet_pkg::BK_DONE: begin
        if (!res_valid || pop) begin
          state_next = jet_pkg::BK_IDLE;
        end
      end
      default: state_next = jet_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    start     = 1'b0;
    res_load  = 1'b0;
    stat.busy = 1'b1;
    stat.done = 1'b0;
    unique case (state)
      jet_pkg::BK_IDLE: begin
        start     = !q_stat.empty;
        stat.busy = 1'b0;
      end
      jet_pkg::BK_DONE: begin
        res_load  = !res_valid || pop;
        stat.done = 1'b1;
      end
      default: begin
        start = 1'b0;
      end
    endcase
  end

  assign q_pop      = start;
  assign empty      = !res_valid;
  assign iterations = COUNT_BITS'(res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jet_pkg::BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_count <= cnt;
    end
    if (start) begin
      x     <= head.re;
      y     <= head.im;
      cnt   <= '0;
      first <= 1'b1;
      prev  <= PREV_INIT;
    end
    if (state == jet_pkg::BK_MUL) begin
      xx <= x * x;
      yy <= y * y;
      xy <= x * y;
    end
    if (state == jet_pkg::BK_SUM) begin
      modulus <= $unsigned(xx) + $unsigned(yy);
      dif     <= xx - yy;
    end
    if ((state == jet_pkg::BK_CHK) && !stop_chk) begin
      cnt   <= cnt_upd;
      first <= 1'b0;
      x     <= jet_pkg::sat32(nx_wide);
      y     <= jet_pkg::sat32(ny_wide);
      if (!first) begin
        prev <= modulus;
      end
    end
  end

endmodule

// ----- rtl/core/julia_escape_time.sv -----
// julia escape-time counter: one count per start point, c from configuration
// steps: a point goes through the front register and the queue into the engine, which runs passes of
//   multiply, sum and check: a first pass plus one pass per counted iteration, plus one more when
//   escape or settling stops it; then the result register; a zero limit point takes no pass
// the single multiply/sum/check engine takes a new point only once it is through with the last one
// reset: synchronous, clears queues and handshake state, c to 0, limit 255, threshold 67
module julia_escape_time #(
  parameter int COUNT_BITS      = 16,
  parameter int COORD_FRAC_BITS = 26
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input side, queue style
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [jet_pkg::COORD_BITS-1:0] start_real,
  input  logic signed [jet_pkg::COORD_BITS-1:0] start_imag,
  // result side, queue style
  output logic                                 empty,
  input  logic                                 pop,
  output logic [COUNT_BITS-1:0]                iterations,
  // configuration writes
  input  logic                                 cfg_write,
  input  logic [1:0]                           cfg_index,
  input  logic [jet_pkg::COORD_BITS-1:0]       cfg_data
);

  // limit is clipped to the count width as well as to 16 bits
  localparam logic [jet_pkg::LIMIT_BITS-1:0] LIMIT_MASK =
    (COUNT_BITS >= jet_pkg::LIMIT_BITS) ? {jet_pkg::LIMIT_BITS{1'b1}}
                                        : jet_pkg::LIMIT_BITS'((1 << COUNT_BITS) - 1);

  jet_pkg::cfg_t                    cfg;
  logic [jet_pkg::LIMIT_BITS-1:0]   iteration_limit;

  jet_pkg::queue_stat_t             q_stat;
  jet_pkg::item_t                   q_item;
  jet_pkg::item_t                   q_head;
  logic                             q_push;
  logic                             q_pop;
  jet_pkg::back_stat_t              bk_stat;

  // configuration registers; unknown indexes cannot occur with a 2 bit index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_real      <= '0;
      cfg.offset_imag      <= '0;
      cfg.settle_threshold <= jet_pkg::COORD_BITS'(67);
      iteration_limit      <= jet_pkg::LIMIT_BITS'(255);
    end else if (cfg_write) begin
      unique case (cfg_index)
        jet_pkg::REG_OFFSET_REAL:      cfg.offset_real      <= cfg_data;
        jet_pkg::REG_OFFSET_IMAG:      cfg.offset_imag      <= cfg_data;
        jet_pkg::REG_ITERATION_LIMIT:
          iteration_limit <= cfg_data[jet_pkg::LIMIT_BITS-1:0] & LIMIT_MASK;
        jet_pkg::REG_SETTLE_THRESHOLD: cfg.settle_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: registers each beat and flags points that take no step
  jet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .start_real (start_real),
    .start_imag (start_imag),
    .limit      (iteration_limit),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // decoupling queue
  jet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // back: iterates z = z*z + c and holds the finished count
  jet_back #(
    .COUNT_BITS      (COUNT_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .limit      (iteration_limit),
    .pop        (pop),
    .empty      (empty),
    .iterations (iterations),
    .stat       (bk_stat)
  );

  // both sides come out of reset with nothing in flight
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full && q_stat.empty))
    else $error("beats left in flight after reset");

  // the queue cannot be full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  // a result beat only shows up right after the engine finished a point
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(bk_stat.done))
    else $error("result beat without a finished point");

  // the engine only takes a point when it is idle and the queue has one
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!bk_stat.busy && !q_stat.empty))
    else $error("engine took a point while busy or from an empty queue");

endmodule
